[rtl/length_prefixed_link_negotiator_assert.svh]
// Assertion macros for the link negotiator block.
// Used by the top level only; clk and rst_n must be visible at the point of use.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef LENGTH_PREFIXED_LINK_NEGOTIATOR_ASSERT_SVH
`define LENGTH_PREFIXED_LINK_NEGOTIATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition holds in the same cycle as the antecedent.
`define LPLN_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpln assertion failed: same-cycle check");
// Condition holds in the cycle after the antecedent.
`define LPLN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpln assertion failed: next-cycle check");
`else
`define LPLN_ASSERT_SAME(lbl, ante, cons)
`define LPLN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/lpln_pkg.sv]
// Shared types and constants for the link negotiator.
// No dependencies; imported by every module of the block.
package lpln_pkg;

    localparam int LPLN_MAX_FRAME_LEN = 4096;
    localparam int HDR_W              = 32;
    localparam int FLEN_W             = 13;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2500;

    // op codes
    localparam logic [2:0] OP_ATTACH  = 3'd0;
    localparam logic [2:0] OP_DETACH  = 3'd1;
    localparam logic [2:0] OP_CHECK   = 3'd2;
    localparam logic [2:0] OP_BYTE    = 3'd3;
    localparam logic [2:0] OP_ELAPSED = 3'd4;

    // event codes
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_CONNECTED    = 3'd1;
    localparam logic [2:0] EV_DISCONNECTED = 3'd2;
    localparam logic [2:0] EV_READY        = 3'd3;
    localparam logic [2:0] EV_MALFORMED    = 3'd4;
    localparam logic [2:0] EV_TIMEOUT      = 3'd5;

    typedef enum logic [2:0] {
        ST_UNPLUGGED   = 3'd0,
        ST_DISCOVERING = 3'd1,
        ST_NEGOTIATING = 3'd2,
        ST_READY       = 3'd3,
        ST_REJECTED    = 3'd4
    } lpln_mode_t;

    // Capability strings, first character in the top byte.
    // Version key/value string, 44 bytes.
    localparam int VER_LEN = 44;
    localparam logic [VER_LEN*8-1:0] VER_PATTERN = {
        64'h2270_726F_746F_636F,
        64'h6C5F_7665_7273_696F,
        64'h6E22_3A22_6165_7468,
        64'h6572_636F_7265_2D74,
        64'h6163_7469_6C69_7479,
        32'h2E76_3222
    };
    // "type":"CAPABILITIES", 21 bytes.
    localparam int TYPE_LEN = 21;
    localparam logic [TYPE_LEN*8-1:0] TYPE_PATTERN = {
        64'h2274_7970_6522_3A22,
        64'h4341_5041_4249_4C49,
        40'h5449_4553_22
    };

    typedef struct packed {
        logic [2:0]  op;
        logic        connected;
        logic [7:0]  data_byte;
        logic [15:0] elapsed_ms;
    } lpln_in_t;

    typedef struct packed {
        logic [2:0]        link_state;
        logic [2:0]        event_res;
        logic              body_valid;
        logic [7:0]        body_byte;
        logic              body_last;
        logic [FLEN_W-1:0] frame_length;
    } lpln_out_t;

    // Control handed from the link controller to the match chains.
    typedef struct packed {
        logic       shift;
        logic       clear;
        logic [7:0] data;
    } lpln_match_ctl_t;

endpackage

[rtl/lpln_match_cell.sv]
// One cell of a string match chain: holds "pattern prefix up to here matched".
// Depends on lpln_pkg.
module lpln_match_cell #(
    parameter logic [7:0] CHAR   = 8'h00,
    parameter bit         STICKY = 1'b0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lpln_pkg::lpln_match_ctl_t ctl,
    input  logic                      prev,
    output logic                      hit,
    output logic                      matched
);
    import lpln_pkg::*;

    logic matched_reg;
    logic matched_next;

    assign hit = prev && (ctl.data == CHAR);

    always_comb
    begin
        matched_next = matched_reg;
        if (ctl.clear)
        begin
            matched_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            // last cell keeps its hit for the rest of the body
            matched_next = hit || (STICKY && matched_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg <= 1'b0;
        end
        else
        begin
            matched_reg <= matched_next;
        end
    end

    assign matched = matched_reg;

endmodule

[rtl/lpln_matcher.sv]
// Chain of match cells that finds one fixed string inside a frame body.
// Depends on lpln_pkg and lpln_match_cell.
module lpln_matcher #(
    parameter int                 LEN     = lpln_pkg::VER_LEN,
    parameter logic [LEN*8-1:0]   PATTERN = lpln_pkg::VER_PATTERN
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lpln_pkg::lpln_match_ctl_t ctl,
    output logic                      found
);
    import lpln_pkg::*;

    logic [LEN-1:0] hit;
    logic [LEN-1:0] matched;

    for (genvar i = 0; i < LEN; i++)
    begin : g_cell
        logic prev;
        if (i == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_body
            assign prev = matched[i-1];
        end

        lpln_match_cell #(
            .CHAR   (PATTERN[(LEN-1-i)*8 +: 8]),
            .STICKY (i == LEN-1)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .prev    (prev),
            .hit     (hit[i]),
            .matched (matched[i])
        );
    end

    // includes a completion on the byte being presented now
    assign found = matched[LEN-1] || hit[LEN-1];

endmodule

[rtl/length_prefixed_link_negotiator.sv]
// Top level of the length-prefixed link negotiator.
// Depends on lpln_pkg, lpln_matcher (and its cells) and the assertion header.
// Usage:
//   in_valid/in_stall/in_data carry one command transaction (attach, detach,
//   link check, received byte, elapsed time). Every accepted transaction
//   yields exactly one result transaction on out_valid/out_stall/out_data:
//   link state after the command, event code and the deframed body byte.
//   cfg_valid/cfg_ready/cfg_data writes the negotiation timeout (ms); it is
//   always ready and should be written only while the block is idle.
// Timing:
//   The result is registered, valid in the cycle after accept. Throughput is one
//   transaction per cycle: the whole state update, including one step of the
//   match cell chains, completes in the accept cycle. The output register is
//   the only buffer, so in_stall rises while a held result is stalled.
// Reset:
//   rst_n is asynchronous. Afterwards the backend is detached, the link is
//   unplugged, the frame state is empty and the timeout is 2500 ms.
// Structure:
//   Two chains of match cells, one per capability string, each cell keeping
//   one "prefix matched" bit and passing it to its neighbor on every body byte.
`include "length_prefixed_link_negotiator_assert.svh"

module length_prefixed_link_negotiator #(
    parameter int MAX_FRAME_LEN = lpln_pkg::LPLN_MAX_FRAME_LEN
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lpln_pkg::lpln_in_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output lpln_pkg::lpln_out_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);
    import lpln_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);

    // ---------------- registers ----------------
    logic              attached_reg, attached_next;
    lpln_mode_t        mode_reg, mode_next;
    logic [2:0]        hdr_cnt_reg, hdr_cnt_next;
    logic [HDR_W-1:0]  hdr_val_reg, hdr_val_next;
    logic [CNT_W-1:0]  body_cnt_reg, body_cnt_next;
    logic [15:0]       left_reg, left_next;
    logic [15:0]       timeout_reg, timeout_next;
    logic              out_valid_reg, out_valid_next;
    lpln_out_t         out_data_reg, out_data_next;

    // ---------------- decode ----------------
    logic             accept;
    logic             attach_do, detach_do, unplug_do, connect_do;
    logic             byte_ok, hdr_byte, body_byte, malformed, last_byte, make_ready;
    logic             tick, timeout_hit, countdown, clr;
    logic [HDR_W-1:0] hdr_shift;
    logic [CNT_W-1:0] body_inc;
    logic             found_ver, found_type;
    lpln_match_ctl_t  match_ctl;

    // Output register frees the input while the result is taken.
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        attach_do  = (in_data.op == OP_ATTACH) && !attached_reg;
        detach_do  = (in_data.op == OP_DETACH) && attached_reg;
        unplug_do  = (in_data.op == OP_CHECK) && attached_reg && !in_data.connected
                     && (mode_reg != ST_UNPLUGGED);
        connect_do = (in_data.op == OP_CHECK) && attached_reg && in_data.connected
                     && ((mode_reg == ST_UNPLUGGED) || (mode_reg == ST_DISCOVERING));

        byte_ok   = (in_data.op == OP_BYTE) && attached_reg
                    && ((mode_reg == ST_NEGOTIATING) || (mode_reg == ST_READY));
        // header phase while fewer than four length bytes are in
        hdr_byte  = byte_ok && !hdr_cnt_reg[2];
        body_byte = byte_ok && hdr_cnt_reg[2];
        hdr_shift = {hdr_val_reg[HDR_W-9:0], in_data.data_byte};
        malformed = hdr_byte && (hdr_cnt_reg == 3'd3)
                    && ((hdr_shift == '0) || (hdr_shift > HDR_W'(MAX_FRAME_LEN)));

        body_inc   = body_cnt_reg + CNT_W'(1);
        last_byte  = body_byte && (HDR_W'(body_inc) >= hdr_val_reg);
        make_ready = last_byte && (mode_reg == ST_NEGOTIATING) && found_ver && found_type;

        tick        = (in_data.op == OP_ELAPSED) && attached_reg
                      && (mode_reg == ST_NEGOTIATING) && (in_data.elapsed_ms != 16'd0);
        timeout_hit = tick && (in_data.elapsed_ms >= left_reg);
        countdown   = tick && !timeout_hit;

        // frame state is dropped at frame end, on reject and on unplug
        clr = detach_do || unplug_do || malformed || last_byte || timeout_hit;
    end

    assign match_ctl.shift = accept && body_byte;
    assign match_ctl.clear = accept && clr;
    assign match_ctl.data  = in_data.data_byte;

    lpln_matcher #(
        .LEN     (VER_LEN),
        .PATTERN (VER_PATTERN)
    ) u_ver_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (match_ctl),
        .found (found_ver)
    );

    lpln_matcher #(
        .LEN     (TYPE_LEN),
        .PATTERN (TYPE_PATTERN)
    ) u_type_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (match_ctl),
        .found (found_type)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        attached_next = attached_reg;
        mode_next     = mode_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        hdr_val_next  = hdr_val_reg;
        body_cnt_next = body_cnt_reg;
        left_next     = left_reg;
        timeout_next  = timeout_reg;

        if (cfg_valid && cfg_ready)
        begin
            timeout_next = cfg_data;
        end

        if (accept)
        begin
            if (attach_do)
            begin
                attached_next = 1'b1;
                mode_next     = ST_DISCOVERING;
            end
            if (detach_do)
            begin
                attached_next = 1'b0;
                mode_next     = ST_UNPLUGGED;
            end
            if (unplug_do)
            begin
                mode_next = ST_UNPLUGGED;
            end
            if (connect_do)
            begin
                mode_next = ST_NEGOTIATING;
                left_next = timeout_reg;
            end
            if (hdr_byte)
            begin
                hdr_cnt_next = hdr_cnt_reg + 3'd1;
                hdr_val_next = hdr_shift;
            end
            if (body_byte)
            begin
                body_cnt_next = body_inc;
            end
            if (malformed || timeout_hit)
            begin
                mode_next = ST_REJECTED;
            end
            if (make_ready)
            begin
                mode_next = ST_READY;
            end
            if (countdown)
            begin
                left_next = left_reg - in_data.elapsed_ms;
            end
            if (clr)
            begin
                hdr_cnt_next  = 3'd0;
                hdr_val_next  = '0;
                body_cnt_next = '0;
            end
        end
    end

    // ---------------- outputs ----------------
    always_comb
    begin
        out_data_next            = out_data_reg;
        out_valid_next           = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next             = 1'b1;
            out_data_next.link_state   = mode_next;
            out_data_next.event_res    = EV_NONE;
            out_data_next.body_valid   = body_byte;
            out_data_next.body_byte    = body_byte ? in_data.data_byte : 8'd0;
            out_data_next.body_last    = last_byte;
            out_data_next.frame_length = last_byte ? hdr_val_reg[FLEN_W-1:0] : '0;
            if (detach_do || unplug_do)
            begin
                out_data_next.event_res = EV_DISCONNECTED;
            end
            else if (connect_do)
            begin
                out_data_next.event_res = EV_CONNECTED;
            end
            else if (malformed)
            begin
                out_data_next.event_res = EV_MALFORMED;
            end
            else if (timeout_hit)
            begin
                out_data_next.event_res = EV_TIMEOUT;
            end
            else if (make_ready)
            begin
                out_data_next.event_res = EV_READY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attached_reg  <= 1'b0;
            mode_reg      <= ST_UNPLUGGED;
            hdr_cnt_reg   <= 3'd0;
            hdr_val_reg   <= '0;
            body_cnt_reg  <= '0;
            left_reg      <= 16'd0;
            timeout_reg   <= TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            attached_reg  <= attached_next;
            mode_reg      <= mode_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            hdr_val_reg   <= hdr_val_next;
            body_cnt_reg  <= body_cnt_next;
            left_reg      <= left_next;
            timeout_reg   <= timeout_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- checks ----------------
    // every accepted transaction leaves a result behind
    `LPLN_ASSERT_NEXT(a_result_follows, accept, out_valid)
    // no frame state survives outside negotiating and ready
    `LPLN_ASSERT_SAME(a_frame_idle_clear,
        !((mode_reg == ST_NEGOTIATING) || (mode_reg == ST_READY)),
        (hdr_cnt_reg == 3'd0) && (body_cnt_reg == '0))
    // a detached backend always reports unplugged
    `LPLN_ASSERT_SAME(a_detached_unplugged, !attached_reg, mode_reg == ST_UNPLUGGED)
    // the end-of-frame flag comes only with a body byte
    `LPLN_ASSERT_SAME(a_last_has_body, out_valid && out_data.body_last, out_data.body_valid)

endmodule
